### rtl/swbw_pkg.sv
// Types, constants, sine table and arithmetic helpers for the swept band-pass wah.
`default_nettype none
package swbw_pkg;

	localparam int SINE_DEPTH = 1024;
	localparam int SINE_AW    = 11;
	localparam int MULA_W     = 33;
	localparam int MULB_W     = 32;
	localparam int PROD_W     = MULA_W + MULB_W;
	localparam logic [15:0] WET_GAIN = 16'd6554;

	// reciprocals of the series denominators, rounded up and scaled by 2^SER_SHIFT
	localparam int SER_SHIFT = 40;
	localparam logic [63:0] RCP_110 = 64'(((65'd1 << SER_SHIFT) + 65'd109) / 65'd110);
	localparam logic [63:0] RCP_72  = 64'(((65'd1 << SER_SHIFT) + 65'd71) / 65'd72);
	localparam logic [63:0] RCP_42  = 64'(((65'd1 << SER_SHIFT) + 65'd41) / 65'd42);
	localparam logic [63:0] RCP_20  = 64'(((65'd1 << SER_SHIFT) + 65'd19) / 65'd20);
	localparam logic [63:0] RCP_6   = 64'(((65'd1 << SER_SHIFT) + 65'd5) / 65'd6);

	localparam logic [2:0] REG_STEREO = 3'd0;
	localparam logic [2:0] REG_DAMP   = 3'd1;
	localparam logic [2:0] REG_MINF   = 3'd2;
	localparam logic [2:0] REG_MAXF   = 3'd3;
	localparam logic [2:0] REG_STEP   = 3'd4;
	localparam logic [2:0] REG_LEN    = 3'd5;
	localparam logic [2:0] REG_PHASE  = 3'd6;

	typedef struct packed {
		logic signed [15:0] left_sample;
		logic signed [15:0] right_sample;
	} in_item_t;

	typedef struct packed {
		logic signed [15:0] dry_sample;
		logic signed [15:0] wet_sample;
	} out_item_t;

	typedef struct packed {
		logic       start;
		logic [3:0] steps;
	} mul_ctl_t;

	typedef enum logic [3:0] {
		S_IDLE, S_POS, S_FC, S_PH, S_ROM, S_DAMP, S_HP, S_BAND,
		S_BL, S_LOW, S_WL, S_WET, S_OUT
	} state_t;

	typedef logic [15:0] sine_rom_t [0:SINE_DEPTH];

	function automatic sine_rom_t build_sine();
		sine_rom_t rom;
		logic [63:0] rcp [0:4];
		logic [63:0] x;
		logic [63:0] x2;
		logic [63:0] t;
		logic [63:0] s;
		logic [63:0] q;
		logic [127:0] y;
		rcp[0] = RCP_110;
		rcp[1] = RCP_72;
		rcp[2] = RCP_42;
		rcp[3] = RCP_20;
		rcp[4] = RCP_6;
		for (int i = 0; i <= SINE_DEPTH; i++) begin
			x  = (64'(i) * 64'd1686629713) / SINE_DEPTH;
			x2 = (x * x) >> 30;
			t  = 64'd1 << 30;
			for (int k = 0; k < 5; k++) begin
				y = {64'd0, (x2 * t) >> 30} * {64'd0, rcp[k]};
				t = (64'd1 << 30) - y[SER_SHIFT +: 64];
			end
			s = (x * t) >> 30;
			q = (s + (64'd1 << 14)) >> 15;
			if (q > 64'd32768)
				q = 64'd32768;
			rom[i] = q[15:0];
		end
		return rom;
	endfunction

	localparam sine_rom_t SINE_ROM = build_sine();

	// floor of the signed product shifted right by n, given its magnitude and sign
	function automatic logic signed [65:0] mul_shift(input logic [PROD_W-1:0] m,
			input logic neg, input int n);
		logic [65:0] t;
		logic [65:0] r;
		t = {1'b0, m} + (neg ? ((66'd1 << n) - 66'd1) : 66'd0);
		r = t >> n;
		return neg ? -$signed(r) : $signed(r);
	endfunction

	function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
		if (v > 66'sh7FFFFFFF)
			return 32'sh7FFFFFFF;
		else if (v < -66'sh80000000)
			return -32'sh80000000;
		else
			return v[31:0];
	endfunction

	function automatic logic signed [15:0] sat16(input logic signed [65:0] v);
		if (v > 66'sh7FFF)
			return 16'sh7FFF;
		else if (v < -66'sh8000)
			return -16'sh8000;
		else
			return v[15:0];
	endfunction

endpackage
`default_nettype wire

### rtl/swbw_serial_mul.sv
// Unsigned multiplier that takes four bits of the multiplier per cycle, most significant first.
`default_nettype none
module swbw_serial_mul import swbw_pkg::*; (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire mul_ctl_t          ctl,
	input  wire logic [MULA_W-1:0] a,
	input  wire logic [MULB_W-1:0] b,
	output logic [PROD_W-1:0]      prod,
	output logic                   done
);
	logic [MULA_W-1:0] a_q;
	logic [MULB_W-1:0] b_q;
	logic [PROD_W-1:0] acc_q;
	logic [3:0]        cnt_q;
	logic              busy_q;
	logic              done_q;
	logic [5:0]        align;
	logic [MULA_W+3:0] pp;

	assign align = 6'd32 - {ctl.steps, 2'b00};
	assign pp    = a_q * b_q[MULB_W-1 -: 4];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (ctl.start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= ctl.steps;
		end else if (busy_q) begin
			cnt_q <= cnt_q - 4'd1;
			if (cnt_q == 4'd1) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.start) begin
			a_q   <= a;
			b_q   <= b << align;
			acc_q <= '0;
		end else if (busy_q) begin
			acc_q <= (acc_q << 4) + {{(PROD_W-MULA_W-4){1'b0}}, pp};
			b_q   <= b_q << 4;
		end
	end

	assign prod = acc_q;
	assign done = done_q;
endmodule
`default_nettype wire

### rtl/swept_bandpass_wah_unit.sv
// Top level of the swept band-pass wah: sweep, coefficient lookup, state-variable filter.
// Only one frame is in flight: a new request is taken once the last result is loaded for output.
// All six products (sweep offset, sweep phase, damping, band update, low update, wet gain) go
// one after another through a single multiplier that consumes four multiplier bits per cycle,
// 33 digit steps in all; adds, table read, sequencing and output load take further states.
// The result sits in an output register, so the next request is taken while a finished result
// still waits.
`default_nettype none
module swept_bandpass_wah_unit import swbw_pkg::*; (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      in_valid,
	output logic           in_ready,
	input  wire in_item_t  in_data,
	output logic           out_valid,
	input  wire logic      out_ready,
	output out_item_t      out_data,
	input  wire logic      cfg_we,
	input  wire logic [2:0]  cfg_addr,
	input  wire logic [31:0] cfg_wdata
);
	state_t state_q, state_d;

	logic        stereo_q;
	logic [15:0] damp_q;
	logic [14:0] minf_q, maxf_q;
	logic [23:0] step_q, len_q;
	logic [31:0] phase_q;

	logic signed [31:0] band_q, low_q, hp_q;
	logic [23:0]        pos_q;
	logic               desc_q;
	logic signed [15:0] mono_q, wet_q;
	logic [30:0]        fc_q;
	logic [SINE_AW-1:0] addr_q;
	logic               fneg_q, neg_q;
	logic signed [17:0] f_q;
	out_item_t          out_q;
	logic               out_valid_q;

	mul_ctl_t          mctl;
	logic [MULA_W-1:0] mul_a;
	logic [MULB_W-1:0] mul_b;
	logic [PROD_W-1:0] prod;
	logic              mdone;

	logic               accept, out_load;
	logic signed [16:0] lr_sum;
	logic signed [50:0] fc_wide;
	logic [30:0]        fc_next;
	logic [15:0]        rom_val;
	logic [32:0]        band_mag, hp_mag;
	logic [16:0]        f_mag;
	logic signed [65:0] xin;
	logic [23:0]        pos_inc;

	swbw_serial_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (mctl),
		.a      (mul_a),
		.b      (mul_b),
		.prod   (prod),
		.done   (mdone)
	);

	assign accept   = in_valid && in_ready;
	assign out_load = (state_q == S_OUT) && (!out_valid_q || out_ready);
	assign lr_sum   = 17'(in_data.left_sample) + 17'(in_data.right_sample);
	assign band_mag = band_q[31] ? -{band_q[31], band_q} : {band_q[31], band_q};
	assign hp_mag   = hp_q[31] ? -{hp_q[31], hp_q} : {hp_q[31], hp_q};
	assign f_mag    = f_q[17] ? 17'(-f_q) : f_q[16:0];
	assign xin      = 66'($signed({mono_q, 9'b0}));
	assign rom_val  = SINE_ROM[addr_q];
	assign pos_inc  = pos_q + 24'd1;

	always_comb begin
		if (desc_q)
			fc_wide = $signed({20'b0, maxf_q, 16'b0}) - $signed({1'b0, prod[49:0]});
		else
			fc_wide = $signed({20'b0, minf_q, 16'b0}) + $signed({1'b0, prod[49:0]});
		if (fc_wide < 0)
			fc_next = '0;
		else if (fc_wide > 51'sh7FFFFFFF)
			fc_next = 31'h7FFFFFFF;
		else
			fc_next = fc_wide[30:0];
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: if (accept) state_d = S_POS;
			S_POS:  if (mdone) state_d = S_FC;
			S_FC:   state_d = S_PH;
			S_PH:   if (mdone) state_d = S_ROM;
			S_ROM:  state_d = S_DAMP;
			S_DAMP: if (mdone) state_d = S_HP;
			S_HP:   state_d = S_BAND;
			S_BAND: if (mdone) state_d = S_BL;
			S_BL:   state_d = S_LOW;
			S_LOW:  if (mdone) state_d = S_WL;
			S_WL:   state_d = S_WET;
			S_WET:  if (mdone) state_d = S_OUT;
			S_OUT:  if (out_load) state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	always_comb begin
		in_ready   = 1'b0;
		mctl.start = 1'b0;
		mctl.steps = 4'd0;
		mul_a      = '0;
		mul_b      = '0;
		unique case (state_q)
			S_IDLE: begin
				in_ready   = 1'b1;
				mctl.start = in_valid;
				mctl.steps = 4'd7;
				mul_a      = {9'b0, step_q};
				mul_b      = {8'b0, desc_q ? pos_inc : pos_q};
			end
			S_FC: begin
				mctl.start = 1'b1;
				mctl.steps = 4'd8;
				mul_a      = {2'b0, fc_q};
				mul_b      = phase_q;
			end
			S_ROM: begin
				mctl.start = 1'b1;
				mctl.steps = 4'd4;
				mul_a      = band_mag;
				mul_b      = {16'b0, damp_q};
			end
			S_HP: begin
				mctl.start = 1'b1;
				mctl.steps = 4'd5;
				mul_a      = hp_mag;
				mul_b      = {15'b0, f_mag};
			end
			S_BL: begin
				mctl.start = 1'b1;
				mctl.steps = 4'd5;
				mul_a      = band_mag;
				mul_b      = {15'b0, f_mag};
			end
			S_WL: begin
				mctl.start = 1'b1;
				mctl.steps = 4'd4;
				mul_a      = band_mag;
				mul_b      = {16'b0, WET_GAIN};
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			stereo_q    <= 1'b1;
			damp_q      <= 16'd1638;
			minf_q      <= 15'd500;
			maxf_q      <= 15'd3000;
			step_q      <= 24'd2972;
			len_q       <= 24'd55126;
			phase_q     <= 32'd194783;
			band_q      <= '0;
			low_q       <= '0;
			pos_q       <= '0;
			desc_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				unique case (cfg_addr)
					REG_STEREO: stereo_q <= cfg_wdata[0];
					REG_DAMP:   damp_q   <= cfg_wdata[15:0];
					REG_MINF:   minf_q   <= cfg_wdata[14:0];
					REG_MAXF:   maxf_q   <= cfg_wdata[14:0];
					REG_STEP:   step_q   <= cfg_wdata[23:0];
					REG_LEN:    len_q    <= cfg_wdata[23:0];
					REG_PHASE:  phase_q  <= cfg_wdata;
					default: begin
					end
				endcase
			end
			if (state_q == S_BAND && mdone)
				band_q <= sat32(66'(band_q) + mul_shift(prod, neg_q, 15));
			if (state_q == S_LOW && mdone)
				low_q <= sat32(66'(low_q) + mul_shift(prod, neg_q, 15));
			if (out_load) begin
				out_valid_q <= 1'b1;
				// advance the sweep; wrap to zero flips the direction
				if (pos_inc >= len_q || pos_inc == 24'd0) begin
					pos_q  <= '0;
					desc_q <= !desc_q;
				end else begin
					pos_q <= pos_inc;
				end
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept)
			mono_q <= stereo_q ? lr_sum[16:1] : in_data.left_sample;
		if (state_q == S_POS && mdone)
			fc_q <= fc_next;
		if (state_q == S_PH && mdone) begin
			// odd quadrant reads the table backward, upper half negates
			addr_q <= prod[48] ? SINE_AW'(SINE_DEPTH) - {1'b0, prod[47:38]} : {1'b0, prod[47:38]};
			fneg_q <= prod[49];
		end
		if (state_q == S_ROM) begin
			f_q   <= fneg_q ? -$signed({1'b0, rom_val, 1'b0}) : $signed({1'b0, rom_val, 1'b0});
			neg_q <= band_q[31];
		end
		if (state_q == S_DAMP && mdone)
			hp_q <= sat32(xin - 66'(low_q) - mul_shift(prod, neg_q, 14));
		if (state_q == S_HP)
			neg_q <= f_q[17] ^ hp_q[31];
		if (state_q == S_BL)
			neg_q <= f_q[17] ^ band_q[31];
		if (state_q == S_WL)
			neg_q <= band_q[31];
		if (state_q == S_WET && mdone)
			wet_q <= sat16(mul_shift(prod, neg_q, 25));
		if (out_load) begin
			out_q.dry_sample <= mono_q;
			out_q.wet_sample <= wet_q;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

`ifndef SYNTHESIS
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> !in_ready)
		else $error("request taken while a frame is in flight");
	a_sweep_only_on_load: assert property (@(posedge clk) disable iff (!arst_n)
		!out_load |=> $stable(pos_q) && $stable(desc_q))
		else $error("sweep moved without a result");
	a_done_in_wait: assert property (@(posedge clk) disable iff (!arst_n)
		mdone |-> (state_q == S_POS || state_q == S_PH || state_q == S_DAMP ||
			state_q == S_BAND || state_q == S_LOW || state_q == S_WET))
		else $error("multiplier finished outside a wait state");
`endif
endmodule
`default_nettype wire

### test/testbench.sv
// Self-checking testbench for the swept band-pass wah unit.
`default_nettype none

class wah_scoreboard;
	bit              stereo;
	bit [15:0]       damp;
	bit [14:0]       min_hz;
	bit [14:0]       max_hz;
	bit [23:0]       step_q16;
	bit [23:0]       half_len;
	bit [31:0]       ph_per_hz;
	longint          band;
	longint          low;
	bit [23:0]       pos;
	bit              falling;
	longint          sine_q15 [0:1024];
	swbw_pkg::out_item_t pending [$];
	int              errors;
	int              checked;

	function new();
		longint unsigned den [0:4];
		longint unsigned x, x2, t, s, q;
		den[0] = 110; den[1] = 72; den[2] = 42; den[3] = 20; den[4] = 6;
		// quarter-wave sine by a truncated series in Q30
		for (int i = 0; i <= 1024; i++) begin
			x  = (longint'(i) * 64'd1686629713) / 1024;
			x2 = (x * x) >> 30;
			t  = 64'd1 << 30;
			for (int k = 0; k < 5; k++)
				t = (64'd1 << 30) - ((x2 * t) >> 30) / den[k];
			s = (x * t) >> 30;
			q = (s + (64'd1 << 14)) >> 15;
			if (q > 32768)
				q = 32768;
			sine_q15[i] = longint'(q);
		end
		stereo = 1; damp = 1638; min_hz = 500; max_hz = 3000;
		step_q16 = 2972; half_len = 55126; ph_per_hz = 194783;
		band = 0; low = 0; pos = 0; falling = 0;
		errors = 0; checked = 0;
	endfunction

	function void write_reg(logic [2:0] idx, logic [31:0] val);
		case (idx)
			swbw_pkg::REG_STEREO: stereo = val[0];
			swbw_pkg::REG_DAMP:   damp = val[15:0];
			swbw_pkg::REG_MINF:   min_hz = val[14:0];
			swbw_pkg::REG_MAXF:   max_hz = val[14:0];
			swbw_pkg::REG_STEP:   step_q16 = val[23:0];
			swbw_pkg::REG_LEN:    half_len = val[23:0];
			swbw_pkg::REG_PHASE:  ph_per_hz = val[31:0];
			default: ;
		endcase
	endfunction

	function longint sat(longint v, int bits);
		longint hi, lo;
		hi = (longint'(1) <<< (bits - 1)) - 1;
		lo = -hi - 1;
		return v > hi ? hi : (v < lo ? lo : v);
	endfunction

	function longint filter_coef();
		longint fc, sv;
		longint unsigned ph;
		int quad, idx;
		if (falling)
			fc = (longint'(max_hz) <<< 16) - (longint'(pos) + 1) * longint'(step_q16);
		else
			fc = (longint'(min_hz) <<< 16) + longint'(pos) * longint'(step_q16);
		if (fc < 0)
			fc = 0;
		if (fc > 64'sh7FFFFFFF)
			fc = 64'sh7FFFFFFF;
		ph = longint'(fc) * longint'(ph_per_hz);
		quad = int'((ph >> 48) & 3);
		idx = int'((ph & ((64'd1 << 48) - 1)) >> 38);
		sv = quad[0] ? sine_q15[1024 - idx] : sine_q15[idx];
		if (quad[1])
			sv = -sv;
		return 2 * sv;
	endfunction

	function void note_request(swbw_pkg::in_item_t req);
		longint mono, f, hp, wet;
		swbw_pkg::out_item_t res;
		mono = stereo ? (longint'(req.left_sample) + longint'(req.right_sample)) >>> 1
			: longint'(req.left_sample);
		f = filter_coef();
		hp = sat((mono <<< 9) - low - ((band * longint'(damp)) >>> 14), 32);
		band = sat(band + ((f * hp) >>> 15), 32);
		low = sat(low + ((f * band) >>> 15), 32);
		wet = sat((band * 6554) >>> 25, 16);
		res.dry_sample = mono[15:0];
		res.wet_sample = wet[15:0];
		pending.push_back(res);
		pos = pos + 1;
		if (pos >= half_len || pos == 0) begin
			pos = 0;
			falling = ~falling;
		end
	endfunction

	function void check_result(swbw_pkg::out_item_t got);
		swbw_pkg::out_item_t want;
		if (pending.size() == 0) begin
			$error("result with nothing pending: dry %0d wet %0d",
				got.dry_sample, got.wet_sample);
			errors++;
			return;
		end
		want = pending.pop_front();
		checked++;
		if (got.dry_sample !== want.dry_sample) begin
			$error("dry_sample expected %0d actual %0d", want.dry_sample, got.dry_sample);
			errors++;
		end
		if (got.wet_sample !== want.wet_sample) begin
			$error("wet_sample expected %0d actual %0d", want.wet_sample, got.wet_sample);
			errors++;
		end
	endfunction
endclass

module testbench;
	timeunit 1ns;
	timeprecision 1ps;
	import swbw_pkg::*;

	logic        clk = 0;
	logic        arst_n = 0;
	logic        in_valid = 0;
	logic        in_ready;
	in_item_t    in_data = '0;
	logic        out_valid;
	logic        out_ready = 0;
	out_item_t   out_data;
	logic        cfg_we = 0;
	logic [2:0]  cfg_addr = '0;
	logic [31:0] cfg_wdata = '0;

	wah_scoreboard sb = new();
	bit  calm_tx = 0;
	bit  calm_rx = 0;
	bit  hold_rx = 0;
	int  cycles = 0;
	int  sent = 0;
	int  settings = 1;

	swept_bandpass_wah_unit uut (
		.clk, .arst_n, .in_valid, .in_ready, .in_data,
		.out_valid, .out_ready, .out_data, .cfg_we, .cfg_addr, .cfg_wdata
	);

	always #4 clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > 2000000) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	// result side: check, then pick next ready
	initial begin
		int hold;
		forever begin
			@(posedge clk);
			if (out_valid && out_ready)
				sb.check_result(out_data);
			if (hold_rx) begin
				hold_rx <= 0;
				out_ready <= 0;
				for (hold = 0; hold < 600; hold++)
					@(posedge clk);
				out_ready <= 1;
			end else if (calm_rx)
				out_ready <= 1;
			else
				out_ready <= ($urandom_range(99) >= 30);
		end
	end

	task automatic send_request(in_item_t req);
		int gap;
		if (!calm_tx && $urandom_range(99) < 30) begin
			in_valid <= 0;
			gap = $urandom_range(1, 6);
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1;
		in_data <= req;
		do @(posedge clk); while (!in_ready);
		sb.note_request(req);
		sent++;
	endtask

	task automatic drain();
		in_valid <= 0;
		while (sb.pending.size() != 0)
			@(posedge clk);
		repeat (60) @(posedge clk);
	endtask

	task automatic write_reg(logic [2:0] idx, logic [31:0] val);
		@(posedge clk);
		cfg_we <= 1;
		cfg_addr <= idx;
		cfg_wdata <= val;
		sb.write_reg(idx, val);
		@(posedge clk);
		cfg_we <= 0;
	endtask

	task automatic load_setting(bit st, logic [15:0] dmp, logic [14:0] lo_hz,
			logic [14:0] hi_hz, logic [23:0] stp, logic [23:0] len, logic [31:0] ph);
		drain();
		write_reg(REG_STEREO, 32'(st));
		write_reg(REG_DAMP, 32'(dmp));
		write_reg(REG_MINF, 32'(lo_hz));
		write_reg(REG_MAXF, 32'(hi_hz));
		write_reg(REG_STEP, 32'(stp));
		write_reg(REG_LEN, 32'(len));
		write_reg(REG_PHASE, ph);
		settings++;
	endtask

	function automatic logic [15:0] pick_sample();
		case ($urandom_range(9))
			0: return 16'h7FFF;
			1: return 16'h8000;
			2: return 16'($urandom_range(3)) - 16'd1;
			default: return 16'($urandom);
		endcase
	endfunction

	task automatic send_random(int n);
		in_item_t req;
		for (int i = 0; i < n; i++) begin
			// runs of a held level drive the states into saturation
			if ($urandom_range(99) < 15 && i > 0) begin
				// hold previous request
			end else begin
				req.left_sample = pick_sample();
				req.right_sample = pick_sample();
			end
			send_request(req);
		end
	endtask

	initial begin
		in_item_t req;
		logic [15:0] edges [0:5];
		edges[0] = 16'h7FFF; edges[1] = 16'h8000; edges[2] = 16'h0000;
		edges[3] = 16'hFFFF; edges[4] = 16'h0001; edges[5] = 16'h5A5A;
		repeat (6) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// directed: field extremes and odd negative sums at reset settings
		for (int a = 0; a < 6; a++)
			for (int b = 0; b < 3; b++) begin
				req.left_sample = edges[a];
				req.right_sample = edges[(a + b + 1) % 6];
				send_request(req);
			end

		// mono, no damping, full phase range, fast turnaround
		load_setting(0, 16'd0, 15'd0, 15'd24000, 24'hFFFFFF, 24'd3, 32'hFFFFFFFF);
		for (int a = 0; a < 6; a++) begin
			req.left_sample = edges[a];
			req.right_sample = edges[5 - a];
			send_request(req);
		end
		send_random(120);

		// stereo, damping of 32768, inverted range, flip every item
		load_setting(1, 16'd32768, 15'd24000, 15'd0, 24'd1, 24'd1, 32'd1);
		send_random(100);

		// zero half-length and all-ones mask values
		load_setting(1, 16'hFFFF, 15'h7FFF, 15'h7FFF, 24'd70000, 24'd0, 32'd194783);
		send_random(60);

		// backpressure: receiver stalls long while the sender streams
		load_setting(0, 16'd1638, 15'd200, 15'd5000, 24'd40000, 24'd25, 32'd194783);
		calm_tx = 1;
		hold_rx = 1;
		send_random(150);
		calm_tx = 0;

		// steady stretch with no idling on either side
		calm_rx = 1;
		calm_tx = 1;
		send_random(150);
		calm_rx = 0;
		calm_tx = 0;

		for (int p = 0; p < 6; p++) begin
			load_setting(1'($urandom), 16'($urandom_range(32768)),
				15'($urandom_range(24000)), 15'($urandom_range(24000)),
				24'($urandom_range(1, 24'hFFFFFF) >> $urandom_range(23)),
				24'($urandom_range(1, 200)), $urandom_range(1, 32'hFFFFFFFF) >>
				$urandom_range(16));
			send_random(120);
		end

		drain();
		$display("Sent %0d frames over %0d register settings, checked %0d results.",
			sent, settings, sb.checked);
		$display("Covered mono and stereo, sweep turnarounds, saturation and stalls.");
		if (sb.errors == 0 && sb.pending.size() == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end
endmodule
`default_nettype wire

### sim.f
rtl/swbw_pkg.sv
rtl/swbw_serial_mul.sv
rtl/swept_bandpass_wah_unit.sv
test/testbench.sv
